// File: design/dq_pkg.sv
// dq_pkg: types, action codes and default sizes for the double-ended queue
// no dependencies; imported by every module of the block
package dq_pkg;

	localparam int DQ_DEPTH      = 16;
	localparam int DQ_DATA_WIDTH = 8;

	localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [2:0] ACT_PUSH_REAR  = 3'd1;
	localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [2:0] ACT_POP_REAR   = 3'd3;
	localparam logic [2:0] ACT_PEEK_FRONT = 3'd4;
	localparam logic [2:0] ACT_PEEK_REAR  = 3'd5;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] push_value;
	} dq_req_t;

	typedef struct packed {
		logic [7:0] result_value;
		logic       success;
		logic [4:0] element_count;
		logic       is_empty;
		logic       is_full;
	} dq_rsp_t;

	typedef struct packed {
		logic push_front;
		logic push_rear;
		logic pop_front;
		logic pop_rear;
	} dq_cmd_t;

endpackage

// File: design/dq_cell.sv
// dq_cell: one slot of the shifting deque, holds an occupancy bit and an entry
// depends on dq_pkg for the command struct
module dq_cell #(
	parameter int DATA_WIDTH = dq_pkg::DQ_DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dq_pkg::dq_cmd_t       cmd,
	input  logic [DATA_WIDTH-1:0] push_data,
	input  logic                  left_occ,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic                  right_occ,
	input  logic [DATA_WIDTH-1:0] right_data,
	output logic                  occ,
	output logic [DATA_WIDTH-1:0] data,
	output logic                  is_rear
);
	import dq_pkg::*;

	logic                  occ_q;
	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			priority if (cmd.push_front) begin
				occ_q <= left_occ;
			end else if (cmd.pop_front) begin
				occ_q <= right_occ;
			end else if (cmd.push_rear && !occ_q && left_occ) begin
				occ_q <= 1'b1;
			end else if (cmd.pop_rear && occ_q && !right_occ) begin
				occ_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.push_front) begin
			data_q <= left_data;
		end else if (cmd.pop_front) begin
			data_q <= right_data;
		end else if (cmd.push_rear && !occ_q && left_occ) begin
			data_q <= push_data;
		end
	end

	assign occ     = occ_q;
	assign data    = data_q;
	assign is_rear = occ_q && !right_occ;

endmodule

// File: design/double_ended_queue.sv
// double_ended_queue: bounded deque built as a row of shifting cells
// depends on dq_pkg and dq_cell
//
//   port  | dir | handshake          | payload
//   req   | in  | req_valid/req_stall | dq_req_t  action, push_value
//   rsp   | out | rsp_valid/rsp_stall | dq_rsp_t  value, success, count, flags
//
// one request per cycle while req_stall is low; its response shows in the cycle after acceptance
// the front entry always sits in cell 0; pushes and pops at the front shift the whole row
// the rear entry is picked from the cell whose right neighbor is unoccupied
// reset empties the deque at once; entry data is not cleared
// req_stall rises only while a held response is stalled
module double_ended_queue #(
	parameter int DEPTH      = dq_pkg::DQ_DEPTH,
	parameter int DATA_WIDTH = dq_pkg::DQ_DATA_WIDTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  dq_pkg::dq_req_t req_data,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output dq_pkg::dq_rsp_t rsp_data
);
	import dq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic                  accept;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_next;
	logic                  empty;
	logic                  full;
	dq_cmd_t               cmd;
	logic                  ok;
	logic                  sel_front;
	logic                  sel_rear;
	logic [DATA_WIDTH-1:0] push_data;
	logic [DATA_WIDTH-1:0] rear_data;
	logic [DATA_WIDTH-1:0] read_data;
	logic [63:0]           push_ext;
	logic [63:0]           read_ext;
	logic                  rsp_valid_q;
	dq_rsp_t               rsp_q;

	logic                  occ     [DEPTH];
	logic [DATA_WIDTH-1:0] data    [DEPTH];
	logic                  is_rear [DEPTH];

	assign accept    = req_valid && !req_stall;
	assign req_stall = rsp_valid_q && rsp_stall;
	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(DEPTH));
	assign push_ext  = 64'(req_data.push_value);
	assign push_data = push_ext[DATA_WIDTH-1:0];

	always_comb begin
		cmd       = '0;
		ok        = 1'b0;
		sel_front = 1'b0;
		sel_rear  = 1'b0;
		unique case (req_data.action)
			ACT_PUSH_FRONT: begin
				ok             = !full;
				cmd.push_front = accept && !full;
			end
			ACT_PUSH_REAR: begin
				ok            = !full;
				cmd.push_rear = accept && !full;
			end
			ACT_POP_FRONT: begin
				ok            = !empty;
				sel_front     = 1'b1;
				cmd.pop_front = accept && !empty;
			end
			ACT_POP_REAR: begin
				ok           = !empty;
				sel_rear     = 1'b1;
				cmd.pop_rear = accept && !empty;
			end
			ACT_PEEK_FRONT: begin
				ok        = !empty;
				sel_front = 1'b1;
			end
			ACT_PEEK_REAR: begin
				ok       = !empty;
				sel_rear = 1'b1;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		rear_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_data = rear_data | (is_rear[i] ? data[i] : '0);
		end
	end

	always_comb begin
		read_data = '0;
		if (ok && sel_front) begin
			read_data = data[0];
		end else if (ok && sel_rear) begin
			read_data = rear_data;
		end
	end

	assign read_ext = 64'(read_data);

	always_comb begin
		count_next = count_q;
		if (cmd.push_front || cmd.push_rear) begin
			count_next = count_q + CW'(1);
		end else if (cmd.pop_front || cmd.pop_rear) begin
			count_next = count_q - CW'(1);
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic                  l_occ;
		logic [DATA_WIDTH-1:0] l_data;
		logic                  r_occ;
		logic [DATA_WIDTH-1:0] r_data;

		if (g == 0) begin : g_first
			assign l_occ  = 1'b1;
			assign l_data = push_data;
		end else begin : g_mid_l
			assign l_occ  = occ[g-1];
			assign l_data = data[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign r_occ  = 1'b0;
			assign r_data = '0;
		end else begin : g_mid_r
			assign r_occ  = occ[g+1];
			assign r_data = data[g+1];
		end

		dq_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.push_data (push_data),
			.left_occ  (l_occ),
			.left_data (l_data),
			.right_occ (r_occ),
			.right_data(r_data),
			.occ       (occ[g]),
			.data      (data[g]),
			.is_rear   (is_rear[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.result_value  <= read_ext[7:0];
			rsp_q.success       <= ok;
			rsp_q.element_count <= 5'(count_next);
			rsp_q.is_empty      <= (count_next == '0);
			rsp_q.is_full       <= (count_next == CW'(DEPTH));
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// File: design/dq_checker.sv
// dq_checker: port-level checks for the double-ended queue
// depends on dq_pkg; bound to double_ended_queue below
module dq_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_stall,
	input dq_pkg::dq_req_t req_data,
	input logic            rsp_valid,
	input logic            rsp_stall,
	input dq_pkg::dq_rsp_t rsp_data
);
	import dq_pkg::*;

	// every accepted request gets its response in the next cycle
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> rsp_valid)
		else $error("response missing after accepted request");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("stalled response changed");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.is_empty == (rsp_data.element_count == 5'd0))
			&& !(rsp_data.is_empty && rsp_data.is_full))
		else $error("empty/full flags disagree with count");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.success |-> rsp_data.result_value == 8'd0)
		else $error("failed request returned nonzero value");

	// no request taken while a stalled response is held
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("request taken under stalled response");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req_data (req_data),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp_data (rsp_data)
);

// File: tb/double_ended_queue_test.sv
// double_ended_queue_test: self-checking bench for the bounded double-ended queue
// drives random and directed requests, predicts every response in a scoreboard class
// depends on dq_pkg and the double_ended_queue rtl
`timescale 1ns / 1ps

module double_ended_queue_test;
	import dq_pkg::*;

	localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
	localparam logic [2:0] ACT_UNUSED_7 = 3'd7;

	class deque_scoreboard;
		logic [7:0]  ring [DQ_DEPTH];
		int unsigned head;
		int unsigned fill;
		dq_rsp_t     want_q [$];
		int          errors;

		function new();
			head   = 0;
			fill   = 0;
			errors = 0;
		endfunction

		function int pending();
			return want_q.size();
		endfunction

		function void note(dq_req_t r);
			dq_rsp_t     e;
			int unsigned tail;
			e = '0;
			tail = (head + fill + DQ_DEPTH - 1) % DQ_DEPTH;
			case (r.action)
				ACT_PUSH_FRONT: if (fill < DQ_DEPTH) begin
					head = (head + DQ_DEPTH - 1) % DQ_DEPTH;
					ring[head] = r.push_value;
					fill++;
					e.success = 1'b1;
				end
				ACT_PUSH_REAR: if (fill < DQ_DEPTH) begin
					ring[(head + fill) % DQ_DEPTH] = r.push_value;
					fill++;
					e.success = 1'b1;
				end
				ACT_POP_FRONT: if (fill != 0) begin
					e.result_value = ring[head];
					head = (head + 1) % DQ_DEPTH;
					fill--;
					e.success = 1'b1;
				end
				ACT_POP_REAR: if (fill != 0) begin
					e.result_value = ring[tail];
					fill--;
					e.success = 1'b1;
				end
				ACT_PEEK_FRONT: if (fill != 0) begin
					e.result_value = ring[head];
					e.success = 1'b1;
				end
				ACT_PEEK_REAR: if (fill != 0) begin
					e.result_value = ring[tail];
					e.success = 1'b1;
				end
				default: ;
			endcase
			e.element_count = 5'(fill);
			e.is_empty      = (fill == 0);
			e.is_full       = (fill == DQ_DEPTH);
			want_q.push_back(e);
		endfunction

		function void mismatch(string field, logic [7:0] want, logic [7:0] got);
			$display("%0t %s mismatch: expected %h actual %h", $time, field, want, got);
			errors++;
		endfunction

		function void check(dq_rsp_t got);
			dq_rsp_t e;
			if (want_q.size() == 0) begin
				$display("%0t response with nothing outstanding: expected none actual %h",
					$time, got);
				errors++;
				return;
			end
			e = want_q.pop_front();
			if (got.result_value !== e.result_value)
				mismatch("result_value", e.result_value, got.result_value);
			if (got.success !== e.success)
				mismatch("success", 8'(e.success), 8'(got.success));
			if (got.element_count !== e.element_count)
				mismatch("element_count", 8'(e.element_count), 8'(got.element_count));
			if (got.is_empty !== e.is_empty)
				mismatch("is_empty", 8'(e.is_empty), 8'(got.is_empty));
			if (got.is_full !== e.is_full)
				mismatch("is_full", 8'(e.is_full), 8'(got.is_full));
		endfunction
	endclass

	logic    clk       = 1'b0;
	logic    arst_n    = 1'b0;
	logic    req_valid = 1'b0;
	logic    req_stall;
	dq_req_t req_data  = '0;
	logic    rsp_valid;
	logic    rsp_stall = 1'b0;
	dq_rsp_t rsp_data;

	deque_scoreboard sb;
	int idle_pct  = 0;
	int stall_pct = 0;
	int hold_len  = 0;
	int hold_left = 0;

	double_ended_queue uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver side: long hold-off when asked, random stall otherwise
	always @(negedge clk) begin
		if (hold_len != 0) begin
			hold_left = hold_len;
			hold_len  = 0;
		end
		if (hold_left != 0) begin
			rsp_stall <= 1'b1;
			hold_left--;
		end else
			rsp_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// responses are checked before the request of the same edge is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				sb.check(rsp_data);
			if (req_valid && !req_stall)
				sb.note(req_data);
		end
	end

	task automatic send_op(input logic [2:0] act, input logic [7:0] value);
		dq_req_t r;
		r.action     = act;
		r.push_value = value;
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic run_directed();
		// empty deque: every pop and peek fails, unused codes do nothing; then a push at each end and peeks at both ends
		send_op(ACT_POP_FRONT, 8'h11);
		send_op(ACT_POP_REAR, 8'h22);
		send_op(ACT_PEEK_FRONT, 8'h33);
		send_op(ACT_PEEK_REAR, 8'h44);
		send_op(ACT_UNUSED_6, 8'hFF);
		send_op(ACT_UNUSED_7, 8'h00);
		send_op(ACT_PUSH_FRONT, 8'hFF);
		send_op(ACT_PUSH_REAR, 8'h00);
		send_op(ACT_PEEK_FRONT, 8'h00);
		send_op(ACT_PEEK_REAR, 8'hFF);
		// fill to the top, then refused pushes at both ends, an unused code and a pop at each end
		for (int k = 0; k < DQ_DEPTH - 2; k++)
			send_op(k[0] ? ACT_PUSH_FRONT : ACT_PUSH_REAR, k[1] ? 8'hA5 : 8'h5A);
		send_op(ACT_PUSH_FRONT, 8'h77);
		send_op(ACT_PUSH_REAR, 8'h88);
		send_op(ACT_UNUSED_7, 8'h99);
		send_op(ACT_POP_REAR, 8'h00);
		send_op(ACT_POP_FRONT, 8'h00);
	endtask

	// bursts lean toward pushes or pops so the deque swings between empty and full
	task automatic run_random(input int count);
		int         done;
		int         burst;
		int         push_pct;
		int         roll;
		logic [2:0] act;
		done = 0;
		while (done < count) begin
			burst = $urandom_range(4, 40);
			case ($urandom_range(0, 2))
				0:       push_pct = 80;
				1:       push_pct = 50;
				default: push_pct = 20;
			endcase
			for (int k = 0; k < burst && done < count; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 3)
					act = $urandom_range(0, 1) ? ACT_UNUSED_6 : ACT_UNUSED_7;
				else if ($urandom_range(0, 99) < push_pct)
					act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
				else if ($urandom_range(0, 99) < 70)
					act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR;
				else
					act = $urandom_range(0, 1) ? ACT_PEEK_FRONT : ACT_PEEK_REAR;
				send_op(act, 8'($urandom));
				if (roll >= 3)
					done++;
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		drain();

		idle_pct  = 0;
		stall_pct = 0;
		run_random(300);
		drain();

		idle_pct  = 85;
		stall_pct = 0;
		run_random(300);
		drain();

		idle_pct  = 0;
		stall_pct = 85;
		run_random(300);
		drain();

		idle_pct  = 18;
		stall_pct = 18;
		run_random(300);
		drain();

		// receiver holds off while requests keep coming
		idle_pct  = 0;
		stall_pct = 0;
		hold_len  = 80;
		run_random(40);
		drain();

		repeat (6) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#5000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
